// File: rtl/core/gga_pkg.sv
// Package: shared types, constants and command/status structs for the assignment block.
`timescale 1ns / 1ps
`default_nettype none
package gga_pkg;

  localparam int DIM          = 64;
  localparam int IDX_BITS     = 6;
  localparam int CNT_BITS     = 7;
  localparam int THR_BITS     = 24;
  localparam int FIELD_COST_W = 24;
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_COST_BITS = 24;
  localparam logic [THR_BITS-1:0] THR_RESET = 24'd1280;

  typedef struct packed {
    logic [IDX_BITS-1:0]     meas_row;
    logic [IDX_BITS-1:0]     track_col;
    logic [FIELD_COST_W-1:0] pair_cost;
    logic                    last_entry;
  } in_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] out_row;
    logic [IDX_BITS-1:0] assigned_track;
    logic                matched;
    logic                last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic scan_step;
    logic commit;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic found;
    logic emit_end;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/gga_ctrl.sv
// Controller: sequences load, search passes, commit and result emission.
`timescale 1ns / 1ps
`default_nettype none
module gga_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept_last,
  input  wire gga_pkg::status_t  status,
  output gga_pkg::cmd_t          cmd,
  output logic                   busy
);
  import gga_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // another pass while something was picked
        state_nxt = status.found ? ST_SCAN : ST_EMIT;
      end
      ST_EMIT: begin
        if (status.emit_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.clear = accept_last;
      end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_DRAIN:  cmd           = '0;
      ST_COMMIT: cmd.commit    = 1'b1;
      ST_EMIT:   cmd.emit_step = 1'b1;
      default:   cmd           = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/gga_dp.sv
// Datapath: cost memory, scan pipeline, taken flags, assignment memory, result register.
`timescale 1ns / 1ps
`default_nettype none
module gga_dp #(
  parameter int MAX_ROWS  = gga_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = gga_pkg::DEF_MAX_COLS,
  parameter int COST_BITS = gga_pkg::DEF_COST_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_accept,
  input  wire gga_pkg::in_item_t             in_data,
  input  wire logic                          cfg_we,
  input  wire logic [gga_pkg::THR_BITS-1:0]  cfg_data,
  input  wire gga_pkg::cmd_t                 cmd,
  output gga_pkg::status_t                   status,
  output logic                               out_valid,
  output gga_pkg::out_item_t                 out_data
);
  import gga_pkg::*;

  localparam int NROWS = (MAX_ROWS < DIM) ? MAX_ROWS : DIM;
  localparam int NCOLS = (MAX_COLS < DIM) ? MAX_COLS : DIM;
  localparam int CMP_W = 33;

  logic [COST_BITS-1:0] cost_mem [DIM*DIM];
  logic [IDX_BITS-1:0]  asg_mem  [DIM];

  logic [THR_BITS-1:0]  thr_r;
  logic [CNT_BITS-1:0]  nrows_r;
  logic [DIM-1:0]       row_taken_r;
  logic [DIM-1:0]       col_taken_r;
  logic [IDX_BITS-1:0]  scan_row_r, scan_col_r;
  logic                 rd_v_r;
  logic [IDX_BITS-1:0]  rd_row_r, rd_col_r;
  logic [COST_BITS-1:0] rd_cost_r;
  logic                 found_r;
  logic [COST_BITS-1:0] best_cost_r;
  logic [IDX_BITS-1:0]  best_row_r, best_col_r;
  logic [IDX_BITS-1:0]  emit_row_r;
  logic                 out_valid_r;
  logic [IDX_BITS-1:0]  out_row_r;
  logic [IDX_BITS-1:0]  asg_rd_r;
  logic                 out_matched_r, out_last_r;

  logic                 in_range;
  logic [CNT_BITS-1:0]  row_plus;
  logic [CNT_BITS-1:0]  last_row;
  logic                 eligible;

  assign in_range = ({1'b0, in_data.meas_row} < CNT_BITS'(NROWS)) &&
                    ({1'b0, in_data.track_col} < CNT_BITS'(NCOLS));
  assign row_plus = {1'b0, in_data.meas_row} + CNT_BITS'(1);
  assign last_row = nrows_r - CNT_BITS'(1);

  assign status.scan_end = ({1'b0, scan_row_r} == last_row) &&
                           ({1'b0, scan_col_r} == CNT_BITS'(NCOLS - 1));
  assign status.found    = found_r;
  assign status.emit_end = ({1'b0, emit_row_r} == last_row);

  assign eligible = rd_v_r && !row_taken_r[rd_row_r] && !col_taken_r[rd_col_r] &&
                    (CMP_W'(rd_cost_r) < CMP_W'(thr_r)) &&
                    (!found_r || (rd_cost_r < best_cost_r));

  always_ff @(posedge clk) begin
    if (in_accept && in_range) begin
      cost_mem[{in_data.meas_row, in_data.track_col}] <= COST_BITS'(in_data.pair_cost);
    end
    rd_cost_r <= cost_mem[{scan_row_r, scan_col_r}];
    rd_row_r  <= scan_row_r;
    rd_col_r  <= scan_col_r;
    if (cmd.commit && found_r) begin
      asg_mem[best_row_r] <= best_col_r;
    end
    asg_rd_r <= asg_mem[emit_row_r];
  end

  always_ff @(posedge clk) begin
    if (eligible) begin
      best_cost_r <= rd_cost_r;
      best_row_r  <= rd_row_r;
      best_col_r  <= rd_col_r;
    end
    out_row_r     <= emit_row_r;
    out_matched_r <= row_taken_r[emit_row_r];
    out_last_r    <= status.emit_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      nrows_r     <= '0;
      row_taken_r <= '0;
      col_taken_r <= '0;
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      emit_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_data;
      rd_v_r      <= cmd.scan_step;
      out_valid_r <= cmd.emit_step;
      if (cmd.clear) begin
        nrows_r     <= (row_plus > CNT_BITS'(NROWS)) ? CNT_BITS'(NROWS) : row_plus;
        row_taken_r <= '0;
        col_taken_r <= '0;
        scan_row_r  <= '0;
        scan_col_r  <= '0;
        found_r     <= 1'b0;
        emit_row_r  <= '0;
      end else if (cmd.commit) begin
        // mark the winning pair, restart the search
        if (found_r) begin
          row_taken_r[best_row_r] <= 1'b1;
          col_taken_r[best_col_r] <= 1'b1;
        end
        scan_row_r <= '0;
        scan_col_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (eligible) found_r <= 1'b1;
        if (cmd.scan_step) begin
          if ({1'b0, scan_col_r} == CNT_BITS'(NCOLS - 1)) begin
            scan_col_r <= '0;
            scan_row_r <= scan_row_r + IDX_BITS'(1);
          end else begin
            scan_col_r <= scan_col_r + IDX_BITS'(1);
          end
        end
        if (cmd.emit_step) emit_row_r <= emit_row_r + IDX_BITS'(1);
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_data.out_row        = out_row_r;
  assign out_data.assigned_track = out_matched_r ? asg_rd_r : '0;
  assign out_data.matched        = out_matched_r;
  assign out_data.last_result    = out_last_r;

`ifndef NO_ASSERTIONS
  a_best_row_free: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> !row_taken_r[best_row_r]) else $error("best row already taken");
  a_best_col_free: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> !col_taken_r[best_col_r]) else $error("best column already taken");
  a_best_gated: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (CMP_W'(best_cost_r) < CMP_W'(thr_r))) else $error("best cost not gated");
  a_taken_balance: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(row_taken_r) == $countones(col_taken_r)) else $error("taken flags unbalanced");
`endif

endmodule
`default_nettype wire

// File: rtl/core/greedy_gated_assignment.sv
// Top level: greedy gated assignment of measurement rows to track columns.
//
// Usage:
//   Input channel: drive in_data with start high; a request is taken at a
//   clock edge where start is high and busy is low. Cost entries load one per
//   cycle while idle into a 4096-entry cost memory addressed by row and column.
//   The entry marked last_entry fixes the row count (its row plus one) and
//   starts matching; busy stays high until the last result is on the ports.
//   Matching runs search passes over all rows in use times all columns, one
//   memory read per cycle, each pass a scan, a drain and a commit step; one
//   pass runs for every pair assigned plus a final empty one. Results then
//   stream one per cycle in row order, out_valid high for one cycle each.
//   The receiver cannot stall: every strobed result must be taken.
//   Configuration: cfg_data is written to the gate threshold when cfg_valid
//   and cfg_ready are high; cfg_ready is always high. Write only while idle.
//   Reset (rst_n low, synchronous) returns to idle with the threshold at 5.0
//   in Q16.8; cost memory contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module greedy_gated_assignment #(
  parameter int MAX_ROWS  = gga_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = gga_pkg::DEF_MAX_COLS,
  parameter int COST_BITS = gga_pkg::DEF_COST_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire gga_pkg::in_item_t             in_data,
  output logic                               out_valid,
  output gga_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [gga_pkg::THR_BITS-1:0]  cfg_data
);
  import gga_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_accept;

  assign in_accept = start && !busy;
  assign cfg_ready = 1'b1;

  gga_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_last (in_accept && in_data.last_entry),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy)
  );

  gga_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for greedy gated assignment: directed and random matrices checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

class assign_board;
  logic [23:0] cost_mem [64][64];
  logic [23:0] gate_thr;
  gga_pkg::out_item_t awaited [$];
  int errors;

  function new();
    gate_thr = gga_pkg::THR_RESET;
    errors = 0;
  endfunction

  // store the entry; on the last one run the greedy search and queue one result per row
  function void note_request(gga_pkg::in_item_t it);
    bit row_tk [64];
    bit col_tk [64];
    logic [5:0] asg [64];
    int nrows, br, bc;
    bit found;
    logic [23:0] best, v;
    gga_pkg::out_item_t o;
    cost_mem[it.meas_row][it.track_col] = it.pair_cost;
    if (!it.last_entry) return;
    nrows = int'(it.meas_row) + 1;
    foreach (row_tk[i]) begin
      row_tk[i] = 0; col_tk[i] = 0; asg[i] = '0;
    end
    do begin
      found = 0; best = '0; br = 0; bc = 0;
      for (int r = 0; r < nrows; r++) begin
        if (row_tk[r]) continue;
        for (int c = 0; c < 64; c++) begin
          if (col_tk[c]) continue;
          v = cost_mem[r][c];
          if (v >= gate_thr) continue;
          if (!found || v < best) begin
            found = 1; best = v; br = r; bc = c;
          end
        end
      end
      if (found) begin
        row_tk[br] = 1; col_tk[bc] = 1; asg[br] = bc[5:0];
      end
    end while (found);
    for (int r = 0; r < nrows; r++) begin
      o.out_row = r[5:0];
      o.assigned_track = row_tk[r] ? asg[r] : 6'd0;
      o.matched = row_tk[r];
      o.last_result = (r == nrows - 1);
      awaited = {awaited, o};
    end
  endfunction

  function void check_result(gga_pkg::out_item_t got);
    gga_pkg::out_item_t exp_r;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    exp_r = awaited.pop_front();
    if (got.out_row !== exp_r.out_row)
      $display("%0t: out_row exp %0d got %0d", $time, exp_r.out_row, got.out_row);
    if (got.assigned_track !== exp_r.assigned_track)
      $display("%0t: assigned_track exp %0d got %0d", $time, exp_r.assigned_track,
               got.assigned_track);
    if (got.matched !== exp_r.matched)
      $display("%0t: matched exp %0b got %0b", $time, exp_r.matched, got.matched);
    if (got.last_result !== exp_r.last_result)
      $display("%0t: last_result exp %0b got %0b", $time, exp_r.last_result,
               got.last_result);
    if (got !== exp_r) errors++;
  endfunction
endclass

module tb_top;
  import gga_pkg::*;

  logic clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [THR_BITS-1:0] cfg_data;
  assign_board board;
  int idle_pct;

  greedy_gated_assignment dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("tb_top failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_data);
  end

  task automatic send_request(input logic [5:0] row, input logic [5:0] col,
                              input logic [23:0] cost, input bit last);
    in_item_t it;
    it.meas_row = row; it.track_col = col; it.pair_cost = cost; it.last_entry = last;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    board.note_request(it);
  endtask

  // hold off until every expected result is out and the block has settled
  task automatic drain();
    start <= 1'b0;
    while (board.awaited.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_gate(input logic [23:0] thr);
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.gate_thr = thr;
  endtask

  // matrices stay within the first four rows, which are filled at the start
  task automatic random_matrix();
    int nrows, nent;
    logic [23:0] cost;
    nrows = $urandom_range(1, 4);
    nent = $urandom_range(0, 12);
    for (int k = 0; k <= nent; k++) begin
      if ($urandom_range(1)) cost = 24'($urandom_range(0, 2 * board.gate_thr + 1));
      else cost = 24'($urandom);
      if (k == nent)
        send_request(6'(nrows - 1), 6'($urandom_range(63)), cost, 1'b1);
      else
        send_request(6'($urandom_range(nrows - 1)), 6'($urandom_range(63)), cost, 1'b0);
    end
  endtask

  initial begin
    logic [23:0] thr;
    int sent;
    board = new();
    rst_n = 0; start = 0; in_data = '0; cfg_valid = 0; cfg_data = '0;
    idle_pct = 27;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the first four rows once so that no unwritten entry is ever read
    idle_pct = 0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 64; c++)
        send_request(6'(r), 6'(c), 24'hFFFFFF, (r == 3 && c == 63));
    idle_pct = 27;
    // ties go to the lower row then column; a cost equal to the gate never matches
    send_request(6'd0, 6'd5, 24'd100, 1'b0);
    send_request(6'd1, 6'd5, 24'd100, 1'b0);
    send_request(6'd0, 6'd7, 24'd100, 1'b0);
    send_request(6'd1, 6'd7, 24'd100, 1'b0);
    send_request(6'd2, 6'd0, 24'd1280, 1'b0);
    send_request(6'd2, 6'd1, 24'd1279, 1'b1);
    send_request(6'd0, 6'd63, 24'd0, 1'b1);
    send_request(6'd3, 6'd63, 24'd0, 1'b1);
    drain();
    write_gate(24'd0);
    send_request(6'd3, 6'd2, 24'd0, 1'b0);
    send_request(6'd1, 6'd0, 24'd0, 1'b1);
    drain();
    write_gate(24'hFFFFFF);
    send_request(6'd0, 6'd1, 24'hFFFFFE, 1'b0);
    send_request(6'd1, 6'd1, 24'hFFFFFE, 1'b0);
    send_request(6'd1, 6'd62, 24'hFFFFFF, 1'b1);

    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      idle_pct = (ph < 2) ? 27 : (ph < 4) ? 60 : 0;
      case (ph)
        0: thr = 24'd1280;
        1: thr = 24'hFFFFFF;
        2: thr = 24'd0;
        3: thr = 24'($urandom);
        default: thr = 24'($urandom_range(1, 4096));
      endcase
      write_gate(thr);
      while (sent < (ph + 1) * 25) begin
        random_matrix();
        sent = sent + 7;
        if ($urandom_range(9) == 0) drain();
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end
endmodule
`default_nettype wire
